// ----- rtl/button_debounce_longpress_idle_power_defines.svh -----
// ----------------------------------------------------------------------------
// button_debounce_longpress_idle_power_defines
// Assertion macros shared by the button debounce and idle power RTL.
// ----------------------------------------------------------------------------
`ifndef BUTTON_DEBOUNCE_LONGPRESS_IDLE_POWER_DEFINES_SVH
`define BUTTON_DEBOUNCE_LONGPRESS_IDLE_POWER_DEFINES_SVH

// same-cycle implication, checked out of reset
`define BDLIP_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");

// next-cycle implication, checked out of reset
`define BDLIP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// ----- rtl/bdlip_pkg.sv -----
// ----------------------------------------------------------------------------
// bdlip_pkg
// Types, constants and helpers for the button debounce and idle power block.
// ----------------------------------------------------------------------------
package bdlip_pkg;

    localparam int STAMP_WIDTH      = 32;
    localparam int CFG_INDEX_WIDTH  = 3;
    localparam int CFG_DATA_WIDTH   = 32;
    localparam int DEBOUNCE_WIDTH   = 16;
    localparam int LONG_PRESS_WIDTH = 20;
    localparam int PCT_WIDTH        = 7;
    localparam int TIME_WIDTH_DFLT  = 32;

    localparam logic [DEBOUNCE_WIDTH-1:0]   DEBOUNCE_RST     = 16'd50;
    localparam logic [LONG_PRESS_WIDTH-1:0] LONG_PRESS_RST   = 20'd5000;
    localparam logic                        LONG_PRESS_EN_RST = 1'b1;
    localparam logic [STAMP_WIDTH-1:0]      DIM_AFTER_RST    = 32'd180000;
    localparam logic [STAMP_WIDTH-1:0]      SLEEP_AFTER_RST  = 32'd600000;
    localparam logic [PCT_WIDTH-1:0]        BRIGHT_RST       = 7'd50;
    localparam logic [PCT_WIDTH-1:0]        DIM_RST          = 7'd20;
    localparam logic                        ACTIVE_LOW_RST   = 1'b1;
    localparam logic [PCT_WIDTH-1:0]        PCT_MAX          = 7'd100;

    typedef enum logic [CFG_INDEX_WIDTH-1:0] {
        CFG_DEBOUNCE      = 3'd0,
        CFG_LONG_PRESS    = 3'd1,
        CFG_LONG_PRESS_EN = 3'd2,
        CFG_DIM_AFTER     = 3'd3,
        CFG_SLEEP_AFTER   = 3'd4,
        CFG_BRIGHT        = 3'd5,
        CFG_DIM           = 3'd6,
        CFG_ACTIVE_LOW    = 3'd7
    } t_cfg_reg;

    function automatic logic [PCT_WIDTH-1:0] sat_pct(input logic [PCT_WIDTH-1:0] v);
        return (v > PCT_MAX) ? PCT_MAX : v;
    endfunction

endpackage

// ----- rtl/button_debounce_longpress_idle_power.sv -----
// ----------------------------------------------------------------------------
// button_debounce_longpress_idle_power
// Debounces a button pin, flags presses and long presses, and runs the
// inactivity timer that dims the display and then requests sleep.
//
//   channel  direction  handshake                 payload
//   in       input      i_in_valid / o_in_stall   i_now_ms, i_pin_level
//   out      output     o_out_valid / i_out_stall o_stable_pressed .. o_is_dimmed
//   cfg      input      i_cfg_wr_en               i_cfg_index, i_cfg_data
//
// One transaction per cycle while no stall holds the flow; each tick passes
// through the input register and then the result register.
// The state update and all compares run in the single stage between them.
// Synchronous active-low reset clears control state and loads register defaults.
// A stall at the output holds the result register and, once the input register
// is also full, stalls the input.
// ----------------------------------------------------------------------------
`include "button_debounce_longpress_idle_power_defines.svh"

module button_debounce_longpress_idle_power #(
    parameter int TIME_WIDTH = bdlip_pkg::TIME_WIDTH_DFLT
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_in_valid,
    output logic                                   o_in_stall,
    input  logic [bdlip_pkg::STAMP_WIDTH-1:0]      i_now_ms,
    input  logic                                   i_pin_level,
    output logic                                   o_out_valid,
    input  logic                                   i_out_stall,
    output logic                                   o_stable_pressed,
    output logic                                   o_press_event,
    output logic                                   o_long_press_event,
    output logic                                   o_poll_request,
    output logic                                   o_dim_event,
    output logic                                   o_sleep_event,
    output logic [bdlip_pkg::PCT_WIDTH-1:0]        o_brightness,
    output logic                                   o_is_dimmed,
    input  logic                                   i_cfg_wr_en,
    input  logic [bdlip_pkg::CFG_INDEX_WIDTH-1:0]  i_cfg_index,
    input  logic [bdlip_pkg::CFG_DATA_WIDTH-1:0]   i_cfg_data
);

    localparam int CW = (TIME_WIDTH > bdlip_pkg::STAMP_WIDTH) ? TIME_WIDTH
                                                              : bdlip_pkg::STAMP_WIDTH;

    logic [bdlip_pkg::DEBOUNCE_WIDTH-1:0]   r_debounce_ms;
    logic [bdlip_pkg::LONG_PRESS_WIDTH-1:0] r_long_press_ms;
    logic                                   r_long_press_en;
    logic [bdlip_pkg::STAMP_WIDTH-1:0]      r_dim_after_ms;
    logic [bdlip_pkg::STAMP_WIDTH-1:0]      r_sleep_after_ms;
    logic [bdlip_pkg::PCT_WIDTH-1:0]        r_bright_level;
    logic [bdlip_pkg::PCT_WIDTH-1:0]        r_dim_level;
    logic                                   r_active_low;

    logic                                   r_in_valid;
    logic [bdlip_pkg::STAMP_WIDTH-1:0]      r_in_now;
    logic                                   r_in_pin;

    logic                                   r_last_raw;
    logic [TIME_WIDTH-1:0]                  r_raw_change_time;
    logic                                   r_stable_state;
    logic [TIME_WIDTH-1:0]                  r_press_start_time;
    logic                                   r_long_done;
    logic [TIME_WIDTH-1:0]                  r_activity_time;
    logic                                   r_dim_flag;
    logic [bdlip_pkg::PCT_WIDTH-1:0]        r_cur_bright;

    logic                                   r_out_valid;
    logic                                   r_out_stable;
    logic                                   r_out_press;
    logic                                   r_out_long;
    logic                                   r_out_poll;
    logic                                   r_out_dim;
    logic                                   r_out_sleep;
    logic [bdlip_pkg::PCT_WIDTH-1:0]        r_out_bright;
    logic                                   r_out_dimmed;

    logic                                   n_last_raw;
    logic [TIME_WIDTH-1:0]                  n_raw_change_time;
    logic                                   n_stable_state;
    logic [TIME_WIDTH-1:0]                  n_press_start_time;
    logic                                   n_long_done;
    logic [TIME_WIDTH-1:0]                  n_activity_time;
    logic                                   n_dim_flag;
    logic [bdlip_pkg::PCT_WIDTH-1:0]        n_cur_bright;
    logic                                   n_press;
    logic                                   n_long;
    logic                                   n_poll;
    logic                                   n_dim;
    logic                                   n_sleep;

    logic                                   advance;
    logic [TIME_WIDTH-1:0]                  now_t;
    logic                                   raw;
    logic                                   raw_chg;
    logic [TIME_WIDTH-1:0]                  deb_diff;
    logic [TIME_WIDTH-1:0]                  hold_diff;
    logic [TIME_WIDTH-1:0]                  idle;
    logic                                   deb_ok;
    logic                                   new_stable;

    assign advance    = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !advance;

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_debounce_ms    <= bdlip_pkg::DEBOUNCE_RST;
            r_long_press_ms  <= bdlip_pkg::LONG_PRESS_RST;
            r_long_press_en  <= bdlip_pkg::LONG_PRESS_EN_RST;
            r_dim_after_ms   <= bdlip_pkg::DIM_AFTER_RST;
            r_sleep_after_ms <= bdlip_pkg::SLEEP_AFTER_RST;
            r_bright_level   <= bdlip_pkg::BRIGHT_RST;
            r_dim_level      <= bdlip_pkg::DIM_RST;
            r_active_low     <= bdlip_pkg::ACTIVE_LOW_RST;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                bdlip_pkg::CFG_DEBOUNCE: begin
                    r_debounce_ms <= i_cfg_data[bdlip_pkg::DEBOUNCE_WIDTH-1:0];
                end
                bdlip_pkg::CFG_LONG_PRESS: begin
                    r_long_press_ms <= i_cfg_data[bdlip_pkg::LONG_PRESS_WIDTH-1:0];
                end
                bdlip_pkg::CFG_LONG_PRESS_EN: begin
                    r_long_press_en <= i_cfg_data[0];
                end
                bdlip_pkg::CFG_DIM_AFTER: begin
                    r_dim_after_ms <= i_cfg_data;
                end
                bdlip_pkg::CFG_SLEEP_AFTER: begin
                    r_sleep_after_ms <= i_cfg_data;
                end
                bdlip_pkg::CFG_BRIGHT: begin
                    r_bright_level <= i_cfg_data[bdlip_pkg::PCT_WIDTH-1:0];
                end
                bdlip_pkg::CFG_DIM: begin
                    r_dim_level <= i_cfg_data[bdlip_pkg::PCT_WIDTH-1:0];
                end
                bdlip_pkg::CFG_ACTIVE_LOW: begin
                    r_active_low <= i_cfg_data[0];
                end
                default: begin
                end
            endcase
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall && i_in_valid) begin
            r_in_now <= i_now_ms;
            r_in_pin <= i_pin_level;
        end
    end

    // tick evaluation
    always_comb begin
        now_t   = TIME_WIDTH'(r_in_now);
        raw     = r_active_low ? !r_in_pin : r_in_pin;
        raw_chg = (raw != r_last_raw);

        n_last_raw        = raw;
        n_raw_change_time = raw_chg ? now_t : r_raw_change_time;
        deb_diff          = raw_chg ? '0 : (now_t - r_raw_change_time);
        deb_ok            = CW'(deb_diff) >= CW'(r_debounce_ms);
        new_stable        = deb_ok && (r_stable_state != raw);

        n_stable_state     = r_stable_state;
        n_press_start_time = r_press_start_time;
        n_long_done        = r_long_done;
        n_press            = 1'b0;
        n_long             = 1'b0;
        if (new_stable) begin
            n_stable_state     = raw;
            n_press_start_time = raw ? now_t : '0;
            n_long_done        = 1'b0;
            n_press            = raw;
        end

        hold_diff = new_stable ? '0 : (now_t - r_press_start_time);
        if (deb_ok && r_long_press_en && n_stable_state && !n_long_done &&
            CW'(hold_diff) >= CW'(r_long_press_ms)) begin
            n_long_done = 1'b1;
            n_long      = 1'b1;
        end

        n_poll          = n_press || n_long;
        n_activity_time = n_poll ? now_t : r_activity_time;
        n_cur_bright    = n_poll ? bdlip_pkg::sat_pct(r_bright_level) : r_cur_bright;
        n_dim_flag      = n_poll ? 1'b0 : r_dim_flag;
        idle            = n_poll ? '0 : (now_t - r_activity_time);

        n_sleep = 1'b0;
        n_dim   = 1'b0;
        if (CW'(idle) >= CW'(r_sleep_after_ms)) begin
            n_sleep = 1'b1;
        end else if (!n_dim_flag && CW'(idle) >= CW'(r_dim_after_ms)) begin
            n_cur_bright = bdlip_pkg::sat_pct(r_dim_level);
            n_dim_flag   = 1'b1;
            n_dim        = 1'b1;
        end
    end

    // tracking state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_raw         <= 1'b0;
            r_raw_change_time  <= '0;
            r_stable_state     <= 1'b0;
            r_press_start_time <= '0;
            r_long_done        <= 1'b0;
            r_activity_time    <= '0;
            r_dim_flag         <= 1'b0;
            r_cur_bright       <= bdlip_pkg::BRIGHT_RST;
        end else if (advance) begin
            r_last_raw         <= n_last_raw;
            r_raw_change_time  <= n_raw_change_time;
            r_stable_state     <= n_stable_state;
            r_press_start_time <= n_press_start_time;
            r_long_done        <= n_long_done;
            r_activity_time    <= n_activity_time;
            r_dim_flag         <= n_dim_flag;
            r_cur_bright       <= n_cur_bright;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_stable <= n_stable_state;
            r_out_press  <= n_press;
            r_out_long   <= n_long;
            r_out_poll   <= n_poll;
            r_out_dim    <= n_dim;
            r_out_sleep  <= n_sleep;
            r_out_bright <= n_cur_bright;
            r_out_dimmed <= n_dim_flag;
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_stable_pressed   = r_out_stable;
    assign o_press_event      = r_out_press;
    assign o_long_press_event = r_out_long;
    assign o_poll_request     = r_out_poll;
    assign o_dim_event        = r_out_dim;
    assign o_sleep_event      = r_out_sleep;
    assign o_brightness       = r_out_bright;
    assign o_is_dimmed        = r_out_dimmed;

    `BDLIP_ASSERT_IMPL(a_long_polls, i_clk, i_rst_n,
        o_out_valid && o_long_press_event, o_poll_request)
    `BDLIP_ASSERT_IMPL(a_press_is_stable, i_clk, i_rst_n,
        o_out_valid && o_press_event, o_stable_pressed && o_poll_request)
    `BDLIP_ASSERT_IMPL(a_dim_not_sleep, i_clk, i_rst_n,
        o_out_valid && o_dim_event, o_is_dimmed && !o_sleep_event)
    `BDLIP_ASSERT_IMPL(a_poll_undims, i_clk, i_rst_n,
        o_out_valid && o_poll_request, !o_is_dimmed || o_dim_event)
    `BDLIP_ASSERT_NEXT(a_tick_reaches_out, i_clk, i_rst_n,
        r_in_valid && !o_in_stall, o_out_valid)

endmodule

// ----- bench/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the button debounce, long-press and idle power
// block. Ticks of time stamp and pin level go in one per transaction; a
// predictor inside the bench works out every status result, and a checker
// compares each result field by field. Directed tests cover default timing,
// zero thresholds, long press off and saturated brightness. Random tests
// cover extreme and random register settings under sender and receiver
// stalls.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic                            stable_pressed;
        logic                            press_event;
        logic                            long_press_event;
        logic                            poll_request;
        logic                            dim_event;
        logic                            sleep_event;
        logic [bdlip_pkg::PCT_WIDTH-1:0] brightness;
        logic                            is_dimmed;
    } t_tick_status;

    logic                                  clk = 1'b0;
    logic                                  rst_n = 1'b0;
    logic                                  in_valid = 1'b0;
    logic                                  in_stall;
    logic [bdlip_pkg::STAMP_WIDTH-1:0]     now_ms = '0;
    logic                                  pin_level = 1'b0;
    logic                                  out_valid;
    logic                                  out_stall = 1'b0;
    t_tick_status                          seen;
    logic                                  cfg_wr_en = 1'b0;
    logic [bdlip_pkg::CFG_INDEX_WIDTH-1:0] cfg_index = '0;
    logic [bdlip_pkg::CFG_DATA_WIDTH-1:0]  cfg_data = '0;

    button_debounce_longpress_idle_power u_top (
        .i_clk              (clk),
        .i_rst_n            (rst_n),
        .i_in_valid         (in_valid),
        .o_in_stall         (in_stall),
        .i_now_ms           (now_ms),
        .i_pin_level        (pin_level),
        .o_out_valid        (out_valid),
        .i_out_stall        (out_stall),
        .o_stable_pressed   (seen.stable_pressed),
        .o_press_event      (seen.press_event),
        .o_long_press_event (seen.long_press_event),
        .o_poll_request     (seen.poll_request),
        .o_dim_event        (seen.dim_event),
        .o_sleep_event      (seen.sleep_event),
        .o_brightness       (seen.brightness),
        .o_is_dimmed        (seen.is_dimmed),
        .i_cfg_wr_en        (cfg_wr_en),
        .i_cfg_index        (cfg_index),
        .i_cfg_data         (cfg_data)
    );

    // register copies
    logic [bdlip_pkg::DEBOUNCE_WIDTH-1:0]   debounce_len = bdlip_pkg::DEBOUNCE_RST;
    logic [bdlip_pkg::LONG_PRESS_WIDTH-1:0] long_len     = bdlip_pkg::LONG_PRESS_RST;
    logic                                   long_on      = bdlip_pkg::LONG_PRESS_EN_RST;
    logic [bdlip_pkg::STAMP_WIDTH-1:0]      dim_delay    = bdlip_pkg::DIM_AFTER_RST;
    logic [bdlip_pkg::STAMP_WIDTH-1:0]      sleep_delay  = bdlip_pkg::SLEEP_AFTER_RST;
    logic [bdlip_pkg::PCT_WIDTH-1:0]        bright_pct   = bdlip_pkg::BRIGHT_RST;
    logic [bdlip_pkg::PCT_WIDTH-1:0]        dim_pct      = bdlip_pkg::DIM_RST;
    logic                                   pol_low      = bdlip_pkg::ACTIVE_LOW_RST;

    // button and display state
    logic                              pin_seen         = 1'b0;
    logic [bdlip_pkg::STAMP_WIDTH-1:0] pin_change_at    = '0;
    logic                              held             = 1'b0;
    logic [bdlip_pkg::STAMP_WIDTH-1:0] hold_start_at    = '0;
    logic                              long_fired       = 1'b0;
    logic [bdlip_pkg::STAMP_WIDTH-1:0] last_activity_at = '0;
    logic                              dimmed           = 1'b0;
    logic [bdlip_pkg::PCT_WIDTH-1:0]   shown_pct        = bdlip_pkg::BRIGHT_RST;

    t_tick_status awaited_status[$];
    t_tick_status want_now;

    int in_idle_pct    = 0;
    int out_idle_pct   = 0;
    int tick_count     = 0;
    int write_count    = 0;
    int mismatch_count = 0;
    int press_count    = 0;
    int long_count     = 0;
    int dim_count      = 0;
    int sleep_count    = 0;
    logic [bdlip_pkg::STAMP_WIDTH-1:0] clock_ms = '0;
    logic                              pin_now  = 1'b0;

    initial begin
        forever #4 clk = ~clk;
    end

    initial begin
        #2_000_000;
        $display("Timeout with %0d results outstanding", awaited_status.size());
        $display("*** FAILED ***");
        $finish;
    end

    function automatic t_tick_status step_button_power(
        input logic [bdlip_pkg::STAMP_WIDTH-1:0] t,
        input logic pin);
        t_tick_status                      r;
        logic                              pressed_raw;
        logic [bdlip_pkg::STAMP_WIDTH-1:0] idle_ms;
        r = '0;
        pressed_raw = pol_low ? ~pin : pin;
        if (pressed_raw != pin_seen) begin
            pin_seen = pressed_raw;
            pin_change_at = t;
        end
        if (bdlip_pkg::STAMP_WIDTH'(t - pin_change_at) >= debounce_len) begin
            if (held != pressed_raw) begin
                held = pressed_raw;
                hold_start_at = pressed_raw ? t : '0;
                long_fired = 1'b0;
                if (pressed_raw) begin
                    r.press_event = 1'b1;
                    r.poll_request = 1'b1;
                    last_activity_at = t;
                    shown_pct = (bright_pct > 7'd100) ? 7'd100 : bright_pct;
                    dimmed = 1'b0;
                end
            end
            if (long_on && held && !long_fired &&
                bdlip_pkg::STAMP_WIDTH'(t - hold_start_at) >= long_len) begin
                long_fired = 1'b1;
                r.long_press_event = 1'b1;
                r.poll_request = 1'b1;
                last_activity_at = t;
                shown_pct = (bright_pct > 7'd100) ? 7'd100 : bright_pct;
                dimmed = 1'b0;
            end
        end
        idle_ms = t - last_activity_at;
        if (idle_ms >= sleep_delay) begin
            r.sleep_event = 1'b1;
        end else if (!dimmed && idle_ms >= dim_delay) begin
            shown_pct = (dim_pct > 7'd100) ? 7'd100 : dim_pct;
            dimmed = 1'b1;
            r.dim_event = 1'b1;
        end
        r.stable_pressed = held;
        r.brightness = shown_pct;
        r.is_dimmed = dimmed;
        return r;
    endfunction

    always @(posedge clk) begin
        out_stall <= ($urandom_range(99) < out_idle_pct);
    end

    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall) begin
            if (awaited_status.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("Unexpected status transaction at %0t", $realtime);
            end else begin
                want_now = awaited_status.pop_front();
                if (seen !== want_now) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display({"Mismatch at %0t: stable/press/long/poll/dim/sleep/",
                                  "bright/dimmed exp %b%b%b%b%b%b %0d %b act %b%b%b%b%b%b %0d %b"},
                                 $realtime,
                                 want_now.stable_pressed, want_now.press_event,
                                 want_now.long_press_event, want_now.poll_request,
                                 want_now.dim_event, want_now.sleep_event,
                                 want_now.brightness, want_now.is_dimmed,
                                 seen.stable_pressed, seen.press_event,
                                 seen.long_press_event, seen.poll_request,
                                 seen.dim_event, seen.sleep_event,
                                 seen.brightness, seen.is_dimmed);
                end
            end
        end
    end

    task automatic send_tick(input logic [bdlip_pkg::STAMP_WIDTH-1:0] t, input logic pin);
        t_tick_status want;
        while ($urandom_range(99) < in_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        now_ms    <= t;
        pin_level <= pin;
        do begin
            @(posedge clk);
        end while (in_stall);
        want = step_button_power(t, pin);
        awaited_status.push_back(want);
        tick_count++;
        press_count += want.press_event;
        long_count  += want.long_press_event;
        dim_count   += want.dim_event;
        sleep_count += want.sleep_event;
        clock_ms = t;
        pin_now  = pin;
    endtask

    task automatic wait_for_results();
        in_valid <= 1'b0;
        while (awaited_status.size() != 0) begin
            @(posedge clk);
        end
        repeat (2) @(posedge clk);
    endtask

    task automatic cfg_write(input bdlip_pkg::t_cfg_reg sel,
                             input logic [bdlip_pkg::CFG_DATA_WIDTH-1:0] data);
        cfg_wr_en <= 1'b1;
        cfg_index <= sel;
        cfg_data  <= data;
        @(posedge clk);
        case (sel)
            bdlip_pkg::CFG_DEBOUNCE:
                debounce_len = data[bdlip_pkg::DEBOUNCE_WIDTH-1:0];
            bdlip_pkg::CFG_LONG_PRESS:
                long_len     = data[bdlip_pkg::LONG_PRESS_WIDTH-1:0];
            bdlip_pkg::CFG_LONG_PRESS_EN: long_on     = data[0];
            bdlip_pkg::CFG_DIM_AFTER:     dim_delay   = data;
            bdlip_pkg::CFG_SLEEP_AFTER:   sleep_delay = data;
            bdlip_pkg::CFG_BRIGHT:        bright_pct  = data[bdlip_pkg::PCT_WIDTH-1:0];
            bdlip_pkg::CFG_DIM:           dim_pct     = data[bdlip_pkg::PCT_WIDTH-1:0];
            bdlip_pkg::CFG_ACTIVE_LOW:    pol_low     = data[0];
            default: ;
        endcase
        write_count++;
    endtask

    task automatic apply_settings(input logic [31:0] debounce, input logic [31:0] long_hold,
                                  input logic long_en, input logic [31:0] dim_after,
                                  input logic [31:0] sleep_after, input logic [31:0] bright,
                                  input logic [31:0] dim_lvl, input logic act_low);
        wait_for_results();
        cfg_write(bdlip_pkg::CFG_DEBOUNCE, debounce);
        cfg_write(bdlip_pkg::CFG_LONG_PRESS, long_hold);
        cfg_write(bdlip_pkg::CFG_LONG_PRESS_EN, {31'd0, long_en});
        cfg_write(bdlip_pkg::CFG_DIM_AFTER, dim_after);
        cfg_write(bdlip_pkg::CFG_SLEEP_AFTER, sleep_after);
        cfg_write(bdlip_pkg::CFG_BRIGHT, bright);
        cfg_write(bdlip_pkg::CFG_DIM, dim_lvl);
        cfg_write(bdlip_pkg::CFG_ACTIVE_LOW, {31'd0, act_low});
        cfg_wr_en <= 1'b0;
    endtask

    // mostly debounce-shaped pin activity, with jumps onto every timing edge
    task automatic run_random_ticks(input int count);
        logic [bdlip_pkg::STAMP_WIDTH-1:0] t;
        logic [bdlip_pkg::STAMP_WIDTH-1:0] base;
        logic [bdlip_pkg::STAMP_WIDTH-1:0] span;
        logic [bdlip_pkg::STAMP_WIDTH-1:0] offset;
        logic                              p;
        int                                sel;
        t = clock_ms;
        p = pin_now;
        repeat (count) begin
            sel = $urandom_range(99);
            if (sel < 6) begin
                t = $urandom();
                p = 1'($urandom_range(1));
            end else if (sel < 30) begin
                case ($urandom_range(3))
                    0: begin
                        base = pin_change_at;
                        span = bdlip_pkg::STAMP_WIDTH'(debounce_len);
                    end
                    1: begin
                        base = hold_start_at;
                        span = bdlip_pkg::STAMP_WIDTH'(long_len);
                    end
                    2: begin base = last_activity_at; span = dim_delay;    end
                    default: begin base = last_activity_at; span = sleep_delay; end
                endcase
                offset = $urandom_range(2);
                t = base + span + offset - 1;
            end else begin
                t = t + $urandom_range(debounce_len / 3 + 2);
                if ($urandom_range(99) < 25)
                    p = ~p;
            end
            send_tick(t, p);
        end
    endtask

    task automatic test_default_timing();
        send_tick(32'd0, 1'b1);
        send_tick(32'd30, 1'b0);
        send_tick(32'd79, 1'b0);
        send_tick(32'd80, 1'b0);
        send_tick(32'd5079, 1'b0);
        send_tick(32'd5080, 1'b0);
        send_tick(32'd5100, 1'b1);
        send_tick(32'd5150, 1'b1);
        send_tick(32'd185079, 1'b1);
        send_tick(32'd185080, 1'b1);
        send_tick(32'd605080, 1'b1);
        send_tick(32'hFFFF_FFFF, 1'b1);
        send_tick(32'd0, 1'b0);
    endtask

    task automatic test_zero_thresholds();
        apply_settings(32'd0, 32'd0, 1'b1, 32'd10, 32'd20, 32'd127, 32'd101, 1'b0);
        send_tick(32'd100, 1'b0);
        send_tick(32'd101, 1'b1);
        send_tick(32'd111, 1'b1);
        send_tick(32'd121, 1'b1);
        send_tick(32'd122, 1'b0);
        send_tick(32'd130, 1'b1);
    endtask

    task automatic test_long_press_off();
        apply_settings(32'd5, 32'd0, 1'b0, 32'd1000, 32'd2000, 32'd60, 32'd30, 1'b1);
        send_tick(32'd0, 1'b1);
        send_tick(32'd10, 1'b0);
        send_tick(32'd15, 1'b0);
        send_tick(32'd1015, 1'b0);
        send_tick(32'd2015, 1'b0);
        send_tick(32'd2020, 1'b1);
    endtask

    task automatic test_extreme_settings();
        apply_settings(32'd0, 32'd0, 1'b1, 32'd0, 32'd0, 32'd0, 32'd0, 1'b0);
        run_random_ticks(250);
        apply_settings(32'd65535, 32'd1048575, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                       32'd100, 32'd100, 1'b1);
        run_random_ticks(250);
        apply_settings(32'd3, 32'd0, 1'b0, 32'd500, 32'd400, 32'd127, 32'd101, 1'b1);
        run_random_ticks(250);
    endtask

    task automatic test_random_settings();
        repeat (4) begin
            if (write_count > 40) begin
                in_idle_pct  = 0;
                out_idle_pct = 0;
            end else begin
                in_idle_pct  = 78;
                out_idle_pct = 13;
            end
            apply_settings($urandom_range(40), $urandom_range(300), 1'($urandom_range(1)),
                           $urandom_range(2000), $urandom_range(4000), $urandom_range(127),
                           $urandom_range(127), 1'($urandom_range(1)));
            run_random_ticks(250);
        end
    endtask

    initial begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        in_idle_pct  = 13;
        out_idle_pct = 78;
        test_default_timing();
        test_zero_thresholds();
        test_long_press_off();
        test_extreme_settings();
        test_random_settings();
        wait_for_results();
        repeat (10) @(posedge clk);
        mismatch_count += awaited_status.size();
        $display("Checked %0d ticks across %0d register writes under three stall profiles",
                 tick_count, write_count);
        $display("Saw %0d presses, %0d long presses, %0d dims, %0d sleep ticks; %0d mismatches",
                 press_count, long_count, dim_count, sleep_count, mismatch_count);
        if (mismatch_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

// ----- files.f -----
+incdir+rtl
rtl/bdlip_pkg.sv
rtl/button_debounce_longpress_idle_power.sv
bench/testbench.sv
